>>> rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is held off while reset is asserted.
`define ITCF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ITCF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/itcf_pkg.sv
// -----------------------------------------------------------------------------
// itcf_pkg
// Types, widths, register codes and the CORDIC arctangent table of the
// tilt complementary filter.
// -----------------------------------------------------------------------------
package itcf_pkg;

  // configuration register indexes
  localparam logic [7:0] CFG_BLEND_WEIGHT = 8'd0;
  localparam logic [7:0] CFG_GYRO_X_BIAS  = 8'd1;
  localparam logic [7:0] CFG_GYRO_Y_BIAS  = 8'd2;
  localparam logic [7:0] CFG_GYRO_CPD     = 8'd3;

  localparam logic [15:0] BLEND_WEIGHT_RST = 16'd62915;
  localparam logic [15:0] GYRO_CPD_RST     = 16'd131;

  // CORDIC datapath widths
  localparam int unsigned CW     = 27;       // x / y
  localparam int unsigned ZW     = 27;       // angle, Q16 degrees
  localparam int unsigned ACC_W  = ZW - 8;   // angle, 1/256 degree
  localparam logic signed [ZW-1:0] Z_HALF_TURN = 27'sd11796480;

  // integer square root
  localparam int unsigned RAD_W  = 48;
  localparam int unsigned ROOT_W = RAD_W / 2;

  // gyro increment divider
  localparam int unsigned NUM_W = 41;
  localparam int unsigned DEN_W = 26;

  // shared multiplier operands
  localparam int unsigned MA_W = 18;
  localparam int unsigned MB_W = 34;
  localparam int unsigned MP_W = MA_W + MB_W;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_SQRT_GO,
    ST_DEN,
    ST_DIVY_GO,
    ST_DIVY_WAIT,
    ST_MULX,
    ST_DIVX_GO,
    ST_DIVX_WAIT,
    ST_CR_GO,
    ST_CR_WAIT,
    ST_CP_GO,
    ST_CP_WAIT,
    ST_BR_A,
    ST_BR_B,
    ST_BR_C,
    ST_BP_A,
    ST_BP_B,
    ST_BP_C,
    ST_OUT
  } state_e;

  // atan(2^-i) in degrees, Q16
  function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:  v = 27'sd2949120;
      5'd1:  v = 27'sd1740967;
      5'd2:  v = 27'sd919879;
      5'd3:  v = 27'sd466945;
      5'd4:  v = 27'sd234379;
      5'd5:  v = 27'sd117304;
      5'd6:  v = 27'sd58666;
      5'd7:  v = 27'sd29335;
      5'd8:  v = 27'sd14668;
      5'd9:  v = 27'sd7334;
      5'd10: v = 27'sd3667;
      5'd11: v = 27'sd1833;
      5'd12: v = 27'sd917;
      5'd13: v = 27'sd458;
      5'd14: v = 27'sd229;
      5'd15: v = 27'sd115;
      5'd16: v = 27'sd57;
      5'd17: v = 27'sd29;
      5'd18: v = 27'sd14;
      5'd19: v = 27'sd7;
      5'd20: v = 27'sd4;
      5'd21: v = 27'sd2;
      5'd22: v = 27'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/itcf_ifs.sv
// -----------------------------------------------------------------------------
// itcf_ifs
// Valid/ready channels of the tilt filter: sample in, angles out, config.
// -----------------------------------------------------------------------------
interface itcf_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic        [15:0] elapsed_ms;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_ms,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_ms,
                  output ready);
endinterface

interface itcf_result_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] roll_angle;
  logic signed [23:0] pitch_angle;

  modport source (output valid, roll_angle, pitch_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, output ready);
endinterface

interface itcf_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/itcf_sqrt.sv
// -----------------------------------------------------------------------------
// itcf_sqrt
// Floor integer square root, one result bit per cycle.
// -----------------------------------------------------------------------------
module itcf_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [itcf_pkg::RAD_W-1:0]    rad_i,
  output logic                          done_o,
  output logic [itcf_pkg::ROOT_W-1:0]   root_o
);
  import itcf_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROOT_W);
  localparam int unsigned REM_W = ROOT_W + 2;

  logic                busy_q, done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [RAD_W-1:0]    rad_q;
  logic [REM_W-1:0]    rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [REM_W+1:0]    r2, trial;
  logic                fits;

  assign r2    = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign fits  = r2 >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= fits ? REM_W'(r2 - trial) : REM_W'(r2);
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> rtl/core/itcf_div.sv
// -----------------------------------------------------------------------------
// itcf_div
// Unsigned restoring divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module itcf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [itcf_pkg::NUM_W-1:0]  num_i,
  input  logic [itcf_pkg::DEN_W-1:0]  den_i,
  output logic                        done_o,
  output logic [itcf_pkg::NUM_W-1:0]  quot_o
);
  import itcf_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic               busy_q, done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [NUM_W-1:0]   num_q;
  logic [DEN_W-1:0]   den_q;
  logic [DEN_W-1:0]   rem_q;
  logic [DEN_W:0]     trial;
  logic               fits;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where numerator bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      num_q <= {num_q[NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

>>> rtl/core/itcf_cordic.sv
// -----------------------------------------------------------------------------
// itcf_cordic
// Vectoring CORDIC atan2(y, x), one micro-rotation per cycle, result in
// 1/256 degree rounded half up.
// -----------------------------------------------------------------------------
module itcf_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [itcf_pkg::CW-1:0]    y_i,
  input  logic signed [itcf_pkg::CW-1:0]    x_i,
  output logic                              done_o,
  output logic signed [itcf_pkg::ACC_W-1:0] angle_o
);
  import itcf_pkg::*;

  localparam int unsigned CNT_W = $clog2(STEPS);

  logic                 busy_q, done_q, zero_q;
  logic [CNT_W-1:0]     cnt_q;
  logic signed [CW-1:0] x_q, y_q, xs, ys;
  logic signed [ZW-1:0] z_q, z_rnd;

  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (x_i == '0) && (y_i == '0);
      // left half plane: turn the vector by a half turn first
      if (x_i[CW-1]) begin
        x_q <= -x_i;
        y_q <= -y_i;
        z_q <= y_i[CW-1] ? -Z_HALF_TURN : Z_HALF_TURN;
      end else begin
        x_q <= x_i;
        y_q <= y_i;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (!y_q[CW-1]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_q16(5'(cnt_q));
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_q16(5'(cnt_q));
      end
    end
  end

  assign z_rnd   = z_q + ZW'(128);
  assign done_o  = done_q;
  assign angle_o = zero_q ? '0 : z_rnd[ZW-1:8];

endmodule

>>> rtl/core/imu_tilt_complementary_filter.sv
// After a sample is accepted, no new sample is taken until its result is loaded into the
// output register; the two gyro divisions and the two CORDIC runs use the shared units one
// after another. Ready is high only when idle.
// A finished result waits in an output register while the next sample is taken.
// Reset: estimates clear to zero, registers take their defaults, no result pending.
// -----------------------------------------------------------------------------
// imu_tilt_complementary_filter
// Roll/pitch complementary filter: CORDIC accelerometer tilt blended with
// integrated, bias-corrected gyro rates under a step sequencer.
// -----------------------------------------------------------------------------
module imu_tilt_complementary_filter #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned ANGLE_WIDTH  = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  itcf_sample_if.sink   sample_i,
  itcf_result_if.source result_o,
  itcf_cfg_if.sink      cfg_i
);
  import itcf_pkg::*;

  localparam int unsigned AW  = ANGLE_WIDTH;
  localparam int unsigned SW  = MP_W + 1;   // blend sum
  localparam int unsigned SHW = SW - 16;    // blend sum after the Q16 shift

  state_e state_q, state_d;

  // config
  logic [15:0]        blend_q, cpd_q;
  logic signed [15:0] gxb_q, gyb_q;

  // estimates
  logic signed [AW-1:0] roll_q, pitch_q, roll_d, pitch_d;

  // sample
  logic signed [15:0] ax_q, ay_q, az_q;
  logic [15:0]        dt_q, magx_q, magy_q;
  logic               negx_q, negy_q;
  logic signed [16:0] dx, dy, dx_n, dy_n;

  // shared multiplier
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] prod_q, t_q;
  logic [DEN_W-1:0]       den_q;

  logic signed [32:0]     incx_q, incy_q, inc_new;
  logic signed [ACC_W-1:0] accr_q, accp_q;

  // unit hookups
  logic                    sqrt_start, sqrt_done, sqrt_seen_q;
  logic [ROOT_W-1:0]       root;
  logic                    div_start, div_done;
  logic [NUM_W-1:0]        div_num, quot;
  logic                    cor_start, cor_done;
  logic signed [CW-1:0]    cor_y, cor_x, ax_e, ay_e, az_e;
  logic signed [ACC_W-1:0] cor_angle;

  logic signed [SW-1:0]  bsum;
  logic signed [SHW-1:0] bsh;
  logic                  in_acc, out_load;
  logic [15:0]           cpd_eff;
  logic [31:0]           mag2;

  function automatic logic signed [AW-1:0] sat_aw(input logic signed [SHW-1:0] v);
    logic signed [SHW-1:0] hi, lo;
    hi = $signed({{(SHW-AW+1){1'b0}}, {(AW-1){1'b1}}});
    lo = ~hi;
    if (v > hi) return hi[AW-1:0];
    if (v < lo) return lo[AW-1:0];
    return v[AW-1:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [AW-1:0] v);
    logic signed [SHW-1:0] ve, hi, lo;
    ve = SHW'(v);
    hi = $signed({{(SHW-23){1'b0}}, {23{1'b1}}});
    lo = ~hi;
    if (ve > hi) return hi[23:0];
    if (ve < lo) return lo[23:0];
    return ve[23:0];
  endfunction

  assign in_acc         = sample_i.valid && sample_i.ready;
  assign sample_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready    = 1'b1;

  assign dx   = 17'(sample_i.gyro_x) - 17'(gxb_q);
  assign dy   = 17'(sample_i.gyro_y) - 17'(gyb_q);
  assign dx_n = -dx;
  assign dy_n = -dy;

  assign cpd_eff = (cpd_q == '0) ? 16'd1 : cpd_q;
  assign mag2    = t_q[31:0] + prod_q[31:0];
  assign div_num = NUM_W'({prod_q[31:0], 8'h00}) + NUM_W'(den_q[DEN_W-1:1]);
  assign inc_new = {1'b0, quot[31:0]};
  assign ax_e    = CW'(ax_q);
  assign ay_e    = CW'(ay_q);
  assign az_e    = CW'(az_q);

  assign bsum = SW'(t_q) + SW'(prod_q) + SW'(32768);
  assign bsh  = bsum[SW-1:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      blend_q <= BLEND_WEIGHT_RST;
      gxb_q   <= '0;
      gyb_q   <= '0;
      cpd_q   <= GYRO_CPD_RST;
      roll_q  <= '0;
      pitch_q <= '0;
    end else begin
      state_q <= state_d;
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_BLEND_WEIGHT: blend_q <= cfg_i.data;
          CFG_GYRO_X_BIAS:  gxb_q   <= $signed(cfg_i.data);
          CFG_GYRO_Y_BIAS:  gyb_q   <= $signed(cfg_i.data);
          CFG_GYRO_CPD:     cpd_q   <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_acc) begin
      ax_q   <= sample_i.accel_x;
      ay_q   <= sample_i.accel_y;
      az_q   <= sample_i.accel_z;
      dt_q   <= sample_i.elapsed_ms;
      negx_q <= dx[16];
      negy_q <= dy[16];
      magx_q <= dx[16] ? dx_n[15:0] : dx[15:0];
      magy_q <= dy[16] ? dy_n[15:0] : dy[15:0];
    end
    if (state_q == ST_SQ_B || state_q == ST_BR_B || state_q == ST_BP_B) t_q <= prod_q;
    if (state_q == ST_DEN) den_q <= prod_q[DEN_W-1:0];
    if (state_q == ST_DIVY_WAIT && div_done) incy_q <= negy_q ? -inc_new : inc_new;
    if (state_q == ST_DIVX_WAIT && div_done) incx_q <= negx_q ? -inc_new : inc_new;
    if (state_q == ST_CR_WAIT && cor_done) accr_q <= cor_angle;
    if (state_q == ST_CP_WAIT && cor_done) accp_q <= cor_angle;
  end

  always_comb begin
    state_d    = state_q;
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    cor_start  = 1'b0;
    cor_y      = '0;
    cor_x      = '0;
    out_load   = 1'b0;
    roll_d     = roll_q;
    pitch_d    = pitch_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_SQ_A;
      end
      ST_SQ_A: begin
        mul_a   = MA_W'(ax_q);
        mul_b   = MB_W'(ax_q);
        state_d = ST_SQ_B;
      end
      ST_SQ_B: begin
        mul_a   = MA_W'(az_q);
        mul_b   = MB_W'(az_q);
        state_d = ST_SQRT_GO;
      end
      ST_SQRT_GO: begin
        sqrt_start = 1'b1;
        mul_a      = $signed({2'b00, cpd_eff});
        mul_b      = MB_W'(1000);
        state_d    = ST_DEN;
      end
      ST_DEN: begin
        mul_a   = $signed({2'b00, magy_q});
        mul_b   = $signed({18'd0, dt_q});
        state_d = ST_DIVY_GO;
      end
      ST_DIVY_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIVY_WAIT;
      end
      ST_DIVY_WAIT: begin
        if (div_done) state_d = ST_MULX;
      end
      ST_MULX: begin
        mul_a   = $signed({2'b00, magx_q});
        mul_b   = $signed({18'd0, dt_q});
        state_d = ST_DIVX_GO;
      end
      ST_DIVX_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIVX_WAIT;
      end
      ST_DIVX_WAIT: begin
        if (div_done) state_d = ST_CR_GO;
      end
      ST_CR_GO: begin
        cor_start = 1'b1;
        cor_y     = -(ax_e <<< 8);
        cor_x     = az_e <<< 8;
        state_d   = ST_CR_WAIT;
      end
      ST_CR_WAIT: begin
        if (cor_done) state_d = ST_CP_GO;
      end
      ST_CP_GO: begin
        // root normally finished long ago, it ran during the divisions
        if (sqrt_seen_q) begin
          cor_start = 1'b1;
          cor_y     = ay_e <<< 8;
          cor_x     = $signed(CW'(root));
          state_d   = ST_CP_WAIT;
        end
      end
      ST_CP_WAIT: begin
        if (cor_done) state_d = ST_BR_A;
      end
      ST_BR_A: begin
        mul_a   = $signed({2'b00, blend_q});
        mul_b   = MB_W'(roll_q) + MB_W'(incy_q);
        state_d = ST_BR_B;
      end
      ST_BR_B: begin
        mul_a   = MA_W'(65536) - $signed({2'b00, blend_q});
        mul_b   = MB_W'(accr_q);
        state_d = ST_BR_C;
      end
      ST_BR_C: begin
        roll_d  = sat_aw(bsh);
        state_d = ST_BP_A;
      end
      ST_BP_A: begin
        mul_a   = $signed({2'b00, blend_q});
        mul_b   = MB_W'(pitch_q) + MB_W'(incx_q);
        state_d = ST_BP_B;
      end
      ST_BP_B: begin
        mul_a   = MA_W'(65536) - $signed({2'b00, blend_q});
        mul_b   = MB_W'(accp_q);
        state_d = ST_BP_C;
      end
      ST_BP_C: begin
        pitch_d = sat_aw(bsh);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!result_o.valid || result_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_o.valid <= 1'b0;
    end else if (out_load) begin
      result_o.valid <= 1'b1;
    end else if (result_o.ready) begin
      result_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_o.roll_angle  <= sat24(roll_q);
      result_o.pitch_angle <= sat24(pitch_q);
    end
  end

  itcf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   ({mag2, 16'h0000}),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  itcf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  itcf_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .y_i     (cor_y),
    .x_i     (cor_x),
    .done_o  (cor_done),
    .angle_o (cor_angle)
  );

  // root ready flag: cleared on start, set when the root is done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqrt_seen_q <= 1'b0;
    end else if (sqrt_start || sqrt_done) begin
      sqrt_seen_q <= sqrt_done;
    end
  end

endmodule

>>> rtl/core/itcf_checker.sv
// -----------------------------------------------------------------------------
// itcf_checker
// Port-level checks of the tilt filter, bound onto the top level.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module itcf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_roll,
  input logic [23:0] out_pitch,
  input logic        cfg_ready
);

  // busy after a sample is taken
  `ITCF_ASSERT(a_busy_after_take, clk_i, rst_ni, (in_valid && in_ready) |=> !in_ready, "ready after accept")

  // no word appears right after a sample is taken
  `ITCF_ASSERT(a_no_instant_word, clk_i, rst_ni, (in_valid && in_ready) |=> !$rose(out_valid), "result too early")

  `ITCF_ASSERT(a_cfg_always_ready, clk_i, rst_ni, cfg_ready, "config port stalled")

  `ITCF_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid && !out_ready) |=> (out_valid && $stable(out_roll) && $stable(out_pitch)), "stalled word changed")

endmodule

bind imu_tilt_complementary_filter itcf_checker u_itcf_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (sample_i.valid),
  .in_ready  (sample_i.ready),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .out_roll  (result_o.roll_angle),
  .out_pitch (result_o.pitch_angle),
  .cfg_ready (cfg_i.ready)
);
